// ----- rtl/core/gated_moving_average_detector_defines.svh -----
// Assertion helpers used by the checker file.
`ifndef GATED_MOVING_AVERAGE_DETECTOR_DEFINES_SVH
`define GATED_MOVING_AVERAGE_DETECTOR_DEFINES_SVH

// Same-cycle implication, held off while in reset.
`define GMAD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gmad assertion failed");

// Next-cycle implication, held off while in reset.
`define GMAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gmad assertion failed");

`endif

// ----- rtl/core/gmad_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package gmad_pkg;

  localparam int DATA_W    = 16;
  localparam int SUM_W     = 23;
  localparam int DIV_SHIFT = 30;
  localparam int PROD_W    = SUM_W + DIV_SHIFT;
  localparam int CFG_IDX_W = 2;

  localparam logic CMD_SAMPLE    = 1'b0;
  localparam logic CMD_CALIBRATE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_GATE_LOW      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_HIGH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_MARGIN = 2'd2;

  localparam logic [DATA_W-1:0] GATE_LOW_RST      = 16'd960;
  localparam logic [DATA_W-1:0] GATE_HIGH_RST     = 16'd1900;
  localparam logic [DATA_W-1:0] DETECT_MARGIN_RST = 16'd10;

  typedef struct packed {
    logic              command;
    logic [DATA_W-1:0] capture_value;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic [DATA_W-1:0] mean_value;
    logic              metal_present;
    logic [DATA_W-1:0] setpoint_value;
  } out_item_t;

  typedef struct packed {
    logic              calib;
    logic              acc;
    logic [DATA_W-1:0] cap;
  } queue_item_t;

endpackage
`default_nettype wire

// ----- rtl/core/gmad_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gmad_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [$clog2(DEPTH)-1:0]        waddr,
  input  wire logic [WIDTH-1:0]                wdata,
  input  wire logic [$clog2(DEPTH)-1:0]        raddr,
  output logic      [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/gmad_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gmad_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire gmad_pkg::in_item_t                    in_data,
  input  wire logic                                  cfg_we,
  input  wire logic [gmad_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [gmad_pkg::DATA_W-1:0]           cfg_wdata,
  output logic                                       q_valid,
  input  wire logic                                  q_ready,
  output gmad_pkg::queue_item_t                      q_item,
  output logic      [gmad_pkg::DATA_W-1:0]           detect_margin
);

  logic [gmad_pkg::DATA_W-1:0] gate_low_r;
  logic [gmad_pkg::DATA_W-1:0] gate_high_r;
  logic [gmad_pkg::DATA_W-1:0] margin_r;

  gmad_pkg::queue_item_t slot_r [2];
  logic                  wr_ptr_r;
  logic                  rd_ptr_r;
  logic [1:0]            count_r;
  logic [1:0]            count_nxt;
  logic                  push;
  logic                  pop;
  gmad_pkg::queue_item_t item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_low_r  <= gmad_pkg::GATE_LOW_RST;
      gate_high_r <= gmad_pkg::GATE_HIGH_RST;
      margin_r    <= gmad_pkg::DETECT_MARGIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gmad_pkg::CFG_GATE_LOW:      gate_low_r  <= cfg_wdata;
        gmad_pkg::CFG_GATE_HIGH:     gate_high_r <= cfg_wdata;
        gmad_pkg::CFG_DETECT_MARGIN: margin_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Classify the beat: a sample passes only strictly inside the gate.
  always_comb begin
    item.calib = (in_data.command == gmad_pkg::CMD_CALIBRATE);
    item.acc   = (in_data.command == gmad_pkg::CMD_SAMPLE) &&
                 (in_data.capture_value > gate_low_r) &&
                 (in_data.capture_value < gate_high_r);
    item.cap   = in_data.capture_value;
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = slot_r[rd_ptr_r];
  assign detect_margin = margin_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/gmad_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gmad_back #(
  parameter int WINDOW = 100
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_valid,
  output logic                                  q_ready,
  input  wire gmad_pkg::queue_item_t            q_item,
  input  wire logic [gmad_pkg::DATA_W-1:0]      detect_margin,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output gmad_pkg::out_item_t                   out_data
);

  localparam int ADDR_W = $clog2(WINDOW);
  localparam int unsigned RECIP_I =
    ((2 ** gmad_pkg::DIV_SHIFT) + WINDOW - 1) / WINDOW;
  localparam logic [gmad_pkg::DIV_SHIFT-1:0] RECIP = gmad_pkg::DIV_SHIFT'(RECIP_I);

  logic                         adv;
  logic                         ring_we;
  logic [ADDR_W-1:0]            wp_r;
  logic [ADDR_W-1:0]            wp_nxt;
  logic                         wrapped_r;
  logic                         wrapped_nxt;
  logic [gmad_pkg::DATA_W-1:0]  ram_rdata;
  logic [gmad_pkg::DATA_W-1:0]  old_val;
  logic [gmad_pkg::SUM_W-1:0]   sum_r;
  logic [gmad_pkg::SUM_W-1:0]   sum_nxt;
  logic [gmad_pkg::PROD_W-1:0]  prod;
  logic [gmad_pkg::DATA_W-1:0]  mean_r;
  logic [gmad_pkg::DATA_W-1:0]  baseline_r;
  logic                         detect_r;
  logic                         detect_nxt;
  logic                         p1_v_r;
  logic                         p1_calib_r;
  logic                         p1_acc_r;
  logic                         p2_v_r;
  logic                         p2_acc_r;
  logic                         out_valid_r;
  gmad_pkg::out_item_t          out_data_r;

  // Whole pipe moves together; freeze only when the result beat is stuck.
  assign adv     = !out_valid_r || out_ready;
  assign q_ready = adv;
  assign ring_we = adv && q_valid && q_item.acc;

  always_comb begin
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    if (ring_we) begin
      if (wp_r == ADDR_W'(WINDOW - 1)) begin
        wp_nxt      = '0;
        wrapped_nxt = 1'b1;
      end else begin
        wp_nxt = wp_r + ADDR_W'(1);
      end
    end
  end

  // Read ahead at the next slot so the oldest entry is ready when its
  // replacement shows up. Until the first wrap every slot still reads as zero.
  gmad_ram #(
    .WIDTH (gmad_pkg::DATA_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wp_r),
    .wdata (q_item.cap),
    .raddr (wp_nxt),
    .rdata (ram_rdata)
  );

  assign old_val = wrapped_r ? ram_rdata : '0;
  assign sum_nxt = sum_r - gmad_pkg::SUM_W'(old_val) + gmad_pkg::SUM_W'(q_item.cap);

  // Divide by the window with a reciprocal multiply, exact for 23-bit sums.
  assign prod = gmad_pkg::PROD_W'(sum_r) * gmad_pkg::PROD_W'(RECIP);

  assign detect_nxt = p2_acc_r ?
    ({1'b0, mean_r} > ({1'b0, baseline_r} + {1'b0, detect_margin})) : detect_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      sum_r       <= '0;
      mean_r      <= '0;
      baseline_r  <= '0;
      detect_r    <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      wp_r      <= wp_nxt;
      wrapped_r <= wrapped_nxt;
      if (ring_we) sum_r <= sum_nxt;
      if (p1_v_r && p1_acc_r) begin
        mean_r <= prod[gmad_pkg::DIV_SHIFT +: gmad_pkg::DATA_W];
      end
      if (p1_v_r && p1_calib_r) baseline_r <= mean_r;
      if (p2_v_r) detect_r <= detect_nxt;
      p1_v_r      <= q_valid;
      p2_v_r      <= p1_v_r;
      out_valid_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_calib_r <= q_item.calib;
      p1_acc_r   <= q_item.acc;
      p2_acc_r   <= p1_acc_r;
      out_data_r.accepted       <= p2_acc_r;
      out_data_r.mean_value     <= mean_r;
      out_data_r.metal_present  <= detect_nxt;
      out_data_r.setpoint_value <= baseline_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- rtl/core/gated_moving_average_detector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Gated moving-average metal detector.
// Input beats carry a command and a timer capture value. A sample strictly
// inside (gate_low, gate_high) replaces the oldest ring entry; a calibrate
// beat copies the current window mean into the setpoint. Every input beat
// yields exactly one result beat: accepted flag, mean, metal flag, setpoint.
// Configuration: cfg_we writes cfg_wdata to register cfg_index
// (0 gate_low, 1 gate_high, 2 detect_margin); other indexes are dropped.
// Throughput: one beat per cycle, sustained while out_ready stays high. The ring update, the
// reciprocal-multiply divide and the threshold compare each own one stage.
// Path: an accepted input passes the queue slot, sum, mean and output registers.
// Reset: ring entries count as zero until the write pointer first wraps, so
// no clearing pass is needed; input is taken in the cycle after reset.
// Stall: while out_valid is high and out_ready low the result holds, the
// back end freezes, and the two-entry queue soaks up input until in_ready
// drops.
module gated_moving_average_detector #(
  parameter int WINDOW = 100
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire gmad_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output gmad_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [gmad_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gmad_pkg::DATA_W-1:0]       cfg_wdata
);

  logic                         q_valid;
  logic                         q_ready;
  gmad_pkg::queue_item_t        q_item;
  logic [gmad_pkg::DATA_W-1:0]  detect_margin;

  gmad_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .detect_margin (detect_margin)
  );

  gmad_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .detect_margin (detect_margin),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule
`default_nettype wire

// ----- rtl/core/gmad_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "gated_moving_average_detector_defines.svh"
module gmad_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire gmad_pkg::out_item_t  out_data
);

  sequence s_next_unstored;
    out_valid && out_ready ##1 out_valid && !out_data.accepted;
  endsequence

  sequence s_next_stored;
    out_valid && out_ready ##1 out_valid && out_data.accepted;
  endsequence

  // A stalled result beat holds.
  `GMAD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // A beat right after another that stored nothing keeps the mean.
  `GMAD_ASSERT_IMPL(a_mean_hold, clk, rst_n, s_next_unstored, $stable(out_data.mean_value))

  // Metal flag moves only on a stored sample.
  `GMAD_ASSERT_IMPL(a_flag_hold, clk, rst_n, s_next_unstored, $stable(out_data.metal_present))

  // Stored samples never touch the setpoint.
  `GMAD_ASSERT_IMPL(a_setpoint_hold, clk, rst_n, s_next_stored, $stable(out_data.setpoint_value))

endmodule

bind gated_moving_average_detector gmad_checker u_gmad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

import gmad_pkg::*;

// Tracks the gated ring, the running sum, the mean, the metal flag and the
// setpoint, and holds the readings the block owes us in order.
class average_scoreboard;
  localparam int RING_DEPTH = 100;
  localparam int REPORT_CAP = 60;

  logic [DATA_W-1:0] gate_lo;
  logic [DATA_W-1:0] gate_hi;
  logic [DATA_W-1:0] margin;
  logic [DATA_W-1:0] ring [RING_DEPTH];
  int unsigned       wr_pos;
  logic [SUM_W-1:0]  run_sum;
  logic [DATA_W-1:0] mean_now;
  logic [DATA_W-1:0] setpoint;
  logic              metal;
  out_item_t         owed_readings [$];
  int                errors;
  int                n_checked;
  int                n_stored;
  int                n_rejected;
  int                n_calib;
  int                n_metal;

  function new();
    gate_lo  = GATE_LOW_RST;
    gate_hi  = GATE_HIGH_RST;
    margin   = DETECT_MARGIN_RST;
    foreach (ring[i]) ring[i] = '0;
    wr_pos   = 0;
    run_sum  = '0;
    mean_now = '0;
    setpoint = '0;
    metal    = 1'b0;
  endfunction

  function void set_config(input logic [DATA_W-1:0] lo, hi, mrg);
    gate_lo = lo;
    gate_hi = hi;
    margin  = mrg;
  endfunction

  function int unsigned pick_level();
    if (gate_hi > gate_lo + 1) return $urandom_range(gate_hi - 1, gate_lo + 1);
    return $urandom_range(65535, 0);
  endfunction

  function int waiting();
    return owed_readings.size();
  endfunction

  function void note_capture(input in_item_t beat);
    out_item_t r;
    r.accepted = 1'b0;
    if (beat.command == CMD_CALIBRATE) begin
      setpoint = mean_now;
      n_calib++;
    end else if (beat.capture_value > gate_lo && beat.capture_value < gate_hi) begin
      run_sum      = run_sum - SUM_W'(ring[wr_pos]) + SUM_W'(beat.capture_value);
      ring[wr_pos] = beat.capture_value;
      wr_pos       = (wr_pos == RING_DEPTH - 1) ? 0 : wr_pos + 1;
      mean_now     = DATA_W'(run_sum / RING_DEPTH);
      // 32-bit int threshold: setpoint plus margin never wraps
      metal        = int'(mean_now) > int'(setpoint) + int'(margin);
      r.accepted   = 1'b1;
      n_stored++;
    end else begin
      n_rejected++;
    end
    r.mean_value     = mean_now;
    r.metal_present  = metal;
    r.setpoint_value = setpoint;
    if (metal) n_metal++;
    owed_readings.push_back(r);
  endfunction

  function void report(input string field, input int unsigned want, got);
    errors++;
    if (errors <= REPORT_CAP)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endfunction

  function void check_reading(input out_item_t got);
    out_item_t want;
    n_checked++;
    if (owed_readings.size() == 0) begin
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
      return;
    end
    want = owed_readings.pop_front();
    if (got.accepted !== want.accepted)
      report("accepted", want.accepted, got.accepted);
    if (got.mean_value !== want.mean_value)
      report("mean_value", want.mean_value, got.mean_value);
    if (got.metal_present !== want.metal_present)
      report("metal_present", want.metal_present, got.metal_present);
    if (got.setpoint_value !== want.setpoint_value)
      report("setpoint_value", want.setpoint_value, got.setpoint_value);
  endfunction
endclass

module tb_top;
  localparam int STUCK_LIMIT = 1000;
  localparam int HOLD_CYCLES = 60;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_GATE_LOW;
  logic [DATA_W-1:0]    cfg_wdata = '0;

  bit                   calm      = 1'b0;
  bit                   hold_req  = 1'b0;
  int                   n_configs = 0;

  average_scoreboard sb = new();

  gated_moving_average_detector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: check each beat, idle at random, honor one long hold.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_reading(out_data);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99, 0) >= 6);
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck = 0;
      else stuck++;
    end
    $display("%0t: no beat moved for %0d cycles", $time, STUCK_LIMIT);
    $display("simulation failed");
    $finish;
  end

  task automatic send_beat(input in_item_t beat);
    while (!calm && $urandom_range(99, 0) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    sb.note_capture(beat);
  endtask

  // Hold input until every owed result is back, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input logic [DATA_W-1:0] lo, hi, mrg);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GATE_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_GATE_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= CFG_DETECT_MARGIN;
    cfg_wdata <= mrg;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_config(lo, hi, mrg);
    n_configs++;
  endtask

  function automatic in_item_t mk_beat(input logic cmd, input logic [DATA_W-1:0] val);
    in_item_t b;
    b.command       = cmd;
    b.capture_value = val;
    return b;
  endfunction

  // Mostly in-gate samples around a drifting level, some calibrates, some noise.
  function automatic in_item_t random_beat(input int unsigned level);
    in_item_t    b;
    int unsigned r;
    int          v;
    r               = $urandom_range(99, 0);
    b.command       = (r < 8) ? CMD_CALIBRATE : CMD_SAMPLE;
    b.capture_value = DATA_W'($urandom);
    if (r >= 20 && sb.gate_hi > sb.gate_lo + 1) begin
      v = int'(level) + int'($urandom_range(60, 0)) - 30;
      if (v <= int'(sb.gate_lo)) v = sb.gate_lo + 1;
      if (v >= int'(sb.gate_hi)) v = sb.gate_hi - 1;
      b.capture_value = v[DATA_W-1:0];
    end
    return b;
  endfunction

  task automatic run_phase(input int n_beats, input int pause_at, input int hold_at);
    int unsigned level;
    level = sb.pick_level();
    for (int i = 0; i < n_beats; i++) begin
      if (i % 60 == 59) level = sb.pick_level();
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) drain();
      send_beat(random_beat(level));
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset gates: calibrate on an empty ring, then the gate edges.
    send_beat(mk_beat(CMD_CALIBRATE, 16'hFFFF));
    send_beat(mk_beat(CMD_SAMPLE, 16'd0));
    send_beat(mk_beat(CMD_SAMPLE, 16'hFFFF));
    send_beat(mk_beat(CMD_SAMPLE, GATE_LOW_RST));
    send_beat(mk_beat(CMD_SAMPLE, GATE_LOW_RST + 16'd1));
    send_beat(mk_beat(CMD_SAMPLE, GATE_HIGH_RST - 16'd1));
    send_beat(mk_beat(CMD_SAMPLE, GATE_HIGH_RST));
    // Partly filled ring: mean climbs and trips the flag.
    repeat (5) send_beat(mk_beat(CMD_SAMPLE, 16'd1500));
    send_beat(mk_beat(CMD_CALIBRATE, 16'd0));
    send_beat(mk_beat(CMD_SAMPLE, 16'd1000));

    // Empty gate: nothing passes.
    load_config(16'd500, 16'd501, 16'd10);
    send_beat(mk_beat(CMD_SAMPLE, 16'd500));
    send_beat(mk_beat(CMD_SAMPLE, 16'd501));
    send_beat(mk_beat(CMD_SAMPLE, 16'd0));

    // Wide gate, full margin: setpoint plus margin must not wrap.
    load_config(16'd0, 16'hFFFF, 16'hFFFF);
    repeat (3) send_beat(mk_beat(CMD_SAMPLE, 16'hFFFE));
    send_beat(mk_beat(CMD_CALIBRATE, 16'h5A5A));
    send_beat(mk_beat(CMD_SAMPLE, 16'hFFFE));
    send_beat(mk_beat(CMD_SAMPLE, 16'h0001));

    load_config(GATE_LOW_RST, GATE_HIGH_RST, DETECT_MARGIN_RST);
    run_phase(180, 130, 60);

    calm = 1'b1;
    load_config(16'd0, 16'hFFFF, 16'd0);
    run_phase(180, -1, -1);
    calm = 1'b0;

    load_config(DATA_W'($urandom_range(30000, 0)), 16'd0,
                DATA_W'($urandom_range(200, 0)));
    load_config(sb.gate_lo, DATA_W'(sb.gate_lo + $urandom_range(30000, 2)), sb.margin);
    run_phase(180, 90, -1);

    load_config(16'hFFFF, 16'd0, 16'hFFFF);
    run_phase(60, -1, -1);

    load_config(16'd100, 16'd60000, 16'hFFFF);
    run_phase(120, -1, -1);

    load_config(16'd0, 16'hFFFF, 16'd50);
    run_phase(180, -1, -1);

    in_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("checked %0d results: %0d samples stored, %0d rejected, %0d calibrations",
             sb.n_checked, sb.n_stored, sb.n_rejected, sb.n_calib);
    $display("%0d register sets applied, metal flagged in %0d results, %0d mismatches",
             n_configs, sb.n_metal, sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
